// ----- src/ukd_pkg.sv -----
// Package for the unique key deque: field widths, command and status codes,
// and the control and entry types shared by the cell row and the top level.
// Depends on nothing.
package ukd_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int CMD_W            = 3;
   localparam int HASH_W           = 32;
   localparam int VALUE_W          = 32;
   localparam int STATUS_W         = 3;
   localparam int COUNT_W          = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_REMOVE     = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_LOOKUP     = 3'd5
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_REMOVE
   } cell_op_type;

   typedef enum logic [1:0] {
      PICK_HIT,
      PICK_FRONT,
      PICK_BACK
   } pick_type;

   typedef struct packed {
      logic        load_hit;
      pick_type    pick;
      cell_op_type op;
   } cell_ctrl_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

// ----- src/ukd_if.sv -----
// Valid/ready channel interfaces for the request and response words.
// Depends on ukd_pkg for the field widths.
interface ukd_req_if;
   logic                        valid;
   logic                        ready;
   logic [ukd_pkg::CMD_W-1:0]   command;
   logic [ukd_pkg::HASH_W-1:0]  key_hash;
   logic [ukd_pkg::VALUE_W-1:0] entry_value;

   modport source (output valid, command, key_hash, entry_value, input ready);
   modport sink (input valid, command, key_hash, entry_value, output ready);
endinterface

interface ukd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ukd_pkg::STATUS_W-1:0] status;
   logic [ukd_pkg::HASH_W-1:0]   out_hash;
   logic [ukd_pkg::VALUE_W-1:0]  out_value;
   logic [ukd_pkg::COUNT_W-1:0]  out_count;

   modport source (output valid, status, out_hash, out_value, out_count, input ready);
   modport sink (input valid, status, out_hash, out_value, out_count, output ready);
endinterface

// ----- src/ukd_cell.sv -----
// One cell of the deque row: holds an entry, compares it against the key and
// shifts with its neighbors on front pushes and removals; the first free cell takes a back push.
// Depends on ukd_pkg.
module ukd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ukd_pkg::cell_ctrl_type ctrl,
   input  ukd_pkg::entry_type     new_entry,
   input  logic                   head,
   input  logic                   prev_valid,
   input  ukd_pkg::entry_type     prev_entry,
   input  logic                   next_valid,
   input  ukd_pkg::entry_type     next_entry,
   input  logic                   ahead_in,
   output logic                   ahead_out,
   output logic                   mark,
   output logic                   valid,
   output ukd_pkg::entry_type     entry
);
   import ukd_pkg::*;

   logic      valid_ff, valid_in;
   logic      hit_ff, hit_in;
   entry_type entry_ff, entry_in;

   always_comb begin
      case (ctrl.pick)
         PICK_HIT:   mark = valid_ff & hit_ff;
         PICK_FRONT: mark = valid_ff & head;
         PICK_BACK:  mark = valid_ff & ~next_valid;
         default:    mark = 1'b0;
      endcase
   end

   assign ahead_out = ahead_in | mark;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      hit_in   = ctrl.load_hit ? (valid_ff && entry_ff.hash == new_entry.hash) : hit_ff;
      case (ctrl.op)
         CELL_PUSH_FRONT: begin
            valid_in = prev_valid;
            entry_in = prev_entry;
         end
         CELL_PUSH_BACK: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               entry_in = new_entry;
            end
         end
         CELL_REMOVE: begin
            if (ahead_out) begin
               valid_in = next_valid;
               entry_in = next_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ----- src/unique_key_deque_unit.sv -----
// Top level of the unique key deque: request and response registers, the
// command sequencer and the row of ukd_cell instances.
// Depends on ukd_pkg, ukd_if and ukd_cell.
//
//   channel  direction  handshake          payload
//   req      in         req_port.valid/ready  command, key_hash, entry_value
//   rsp      out        rsp_port.valid/ready  status, out_hash, out_value, out_count
//
// Each command steps through accept, compare in every cell, execute.
// The compare result is registered in the cells before the shift and select.
// A new word is accepted while the previous response waits to be taken.
// Execution stalls while the response register is still full.
// Synchronous reset empties the row at once; no clearing pass is needed.
module unique_key_deque_unit #(
   parameter int CAPACITY = ukd_pkg::DEFAULT_CAPACITY
) (
   input logic      clock,
   input logic      reset,
   ukd_req_if.sink  req_port,
   ukd_rsp_if.source rsp_port
);
   import ukd_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } state_type;

   state_type   state_ff;
   command_type cmd_ff;
   entry_type   key_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   status_type    status_ff, status_in;
   entry_type     out_ff, out_in;
   logic [COUNT_W-1:0] out_count_ff;
   logic [CW+COUNT_W-1:0] count_ext;

   cell_ctrl_type ctrl;
   logic [CAPACITY-1:0] valid_vec;
   logic [CAPACITY-1:0] mark_vec;
   logic [CAPACITY:0]   ahead_vec;
   entry_type           entry_vec [CAPACITY];
   entry_type           pick_entry;
   logic                found;
   logic                full;
   logic                commit;

   assign ahead_vec[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      prev_valid, next_valid;
      entry_type prev_entry, next_entry;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_entry = key_ff;
      end else begin : g_body
         assign prev_valid = valid_vec[i-1];
         assign prev_entry = entry_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_entry = '0;
      end else begin : g_inner
         assign next_valid = valid_vec[i+1];
         assign next_entry = entry_vec[i+1];
      end
      ukd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (key_ff),
         .head       (i == 0),
         .prev_valid (prev_valid),
         .prev_entry (prev_entry),
         .next_valid (next_valid),
         .next_entry (next_entry),
         .ahead_in   (ahead_vec[i]),
         .ahead_out  (ahead_vec[i+1]),
         .mark       (mark_vec[i]),
         .valid      (valid_vec[i]),
         .entry      (entry_vec[i])
      );
   end

   always_comb begin
      pick_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_entry = pick_entry | (mark_vec[i] ? entry_vec[i] : '0);
      end
   end

   assign found  = |mark_vec;
   assign full   = valid_vec[CAPACITY-1];
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      ctrl.load_hit = (state_ff == ST_CMP);
      ctrl.pick     = PICK_HIT;
      ctrl.op       = CELL_HOLD;
      status_in     = STATUS_OK;
      out_in        = '0;
      count_in      = count_ff;
      case (cmd_ff)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (found) begin
               status_in = STATUS_DUPLICATE;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.op  = (cmd_ff == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
               count_in = CW'(count_ff + 1'b1);
            end
         end
         CMD_REMOVE, CMD_LOOKUP: begin
            if (!found) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               out_in = pick_entry;
               if (cmd_ff == CMD_REMOVE) begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = CW'(count_ff - 1'b1);
               end
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            ctrl.pick = (cmd_ff == CMD_POP_FRONT) ? PICK_FRONT : PICK_BACK;
            if (!found) begin
               status_in = STATUS_EMPTY;
            end else begin
               out_in   = pick_entry;
               ctrl.op  = CELL_REMOVE;
               count_in = CW'(count_ff - 1'b1);
            end
         end
         default: begin
         end
      endcase
      if (!commit) begin
         ctrl.op = CELL_HOLD;
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_port.valid) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (commit) begin
                  state_ff <= ST_IDLE;
                  count_ff <= count_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (state_ff == ST_IDLE && req_port.valid) begin
         cmd_ff       <= command_type'(req_port.command);
         key_ff.hash  <= req_port.key_hash;
         key_ff.value <= req_port.entry_value;
      end
      if (commit) begin
         status_ff    <= status_in;
         out_ff       <= out_in;
         out_count_ff <= count_ext[COUNT_W-1:0];
      end
   end

   assign req_port.ready     = (state_ff == ST_IDLE);
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.status    = status_ff;
   assign rsp_port.out_hash  = out_ff.hash;
   assign rsp_port.out_value = out_ff.value;
   assign rsp_port.out_count = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec & ~(valid_vec >> 1)) && (valid_vec[0] || !(|valid_vec)))
      else $error("valid cells are not packed at the front");

   a_single_mark: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $onehot0(mark_vec))
      else $error("more than one cell selected");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside execution");

endmodule

// ----- tb/unique_key_deque_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for unique_key_deque_unit: sends command words with random gaps and
// back-pressure and checks every response word against a model of the deque.
// Depends on ukd_pkg, ukd_if and the unique_key_deque_unit RTL.
module unique_key_deque_unit_tb;
   import ukd_pkg::*;

   localparam int CAPACITY = 16;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam int MAX_REPORTED = 10;
   localparam int POOL_SIZE = 24;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HASH_W-1:0]   hash;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
   } deque_rsp_type;

   logic clock;
   logic reset;

   ukd_req_if req_bus ();
   ukd_rsp_if rsp_bus ();

   unique_key_deque_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   logic [HASH_W-1:0]  held_hash [CAPACITY];
   logic [VALUE_W-1:0] held_value [CAPACITY];
   int held_count = 0;

   deque_rsp_type expected_rsp_q [$];
   deque_rsp_type seen_rsp;
   deque_rsp_type want_rsp;

   int commands_sent = 0;
   int responses_checked = 0;
   int mismatch_count = 0;
   int duplicate_rejects = 0;
   int full_rejects = 0;
   int empty_pops = 0;
   int misses = 0;

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int rsp_hold_cycles = 0;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("unique_key_deque_unit_tb NOT OK");
      $finish;
   end

   function automatic void drop_entry(input int slot);
      for (int i = slot; i < held_count - 1; i++) begin
         held_hash[i] = held_hash[i + 1];
         held_value[i] = held_value[i + 1];
      end
      held_count--;
   endfunction

   function automatic deque_rsp_type apply_deque_command(input logic [CMD_W-1:0] cmd,
                                                         input logic [HASH_W-1:0] h,
                                                         input logic [VALUE_W-1:0] v);
      deque_rsp_type r;
      int hit;
      int slot;
      r = '0;
      r.status = STATUS_OK;
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_hash[i] == h) hit = i;
      end
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (hit >= 0) begin
               r.status = STATUS_DUPLICATE;
               duplicate_rejects++;
            end else if (held_count >= CAPACITY) begin
               r.status = STATUS_FULL;
               full_rejects++;
            end else if (cmd == CMD_PUSH_FRONT) begin
               for (int i = held_count; i > 0; i--) begin
                  held_hash[i] = held_hash[i - 1];
                  held_value[i] = held_value[i - 1];
               end
               held_hash[0] = h;
               held_value[0] = v;
               held_count++;
            end else begin
               held_hash[held_count] = h;
               held_value[held_count] = v;
               held_count++;
            end
         end
         CMD_REMOVE, CMD_LOOKUP: begin
            if (hit < 0) begin
               r.status = STATUS_NOT_FOUND;
               misses++;
            end else begin
               r.hash = held_hash[hit];
               r.value = held_value[hit];
               if (cmd == CMD_REMOVE) drop_entry(hit);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
               empty_pops++;
            end else begin
               slot = (cmd == CMD_POP_FRONT) ? 0 : held_count - 1;
               r.hash = held_hash[slot];
               r.value = held_value[slot];
               drop_entry(slot);
            end
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(held_count);
      return r;
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] h,
                            input logic [VALUE_W-1:0] v);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.key_hash    <= h;
      req_bus.entry_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsp_q.push_back(apply_deque_command(cmd, h, v));
      commands_sent++;
   endtask

   initial begin : response_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_rsp = '{rsp_bus.status, rsp_bus.out_hash, rsp_bus.out_value, rsp_bus.out_count};
         responses_checked++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("%0t: unexpected word: status %0d hash %h value %h count %0d",
                        $realtime, seen_rsp.status, seen_rsp.hash, seen_rsp.value,
                        seen_rsp.count);
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (seen_rsp.status !== want_rsp.status || seen_rsp.hash !== want_rsp.hash ||
                seen_rsp.value !== want_rsp.value || seen_rsp.count !== want_rsp.count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display({"%0t: mismatch: expected status %0d hash %h value %h count %0d,",
                            " got status %0d hash %h value %h count %0d"},
                           $realtime, want_rsp.status, want_rsp.hash, want_rsp.value,
                           want_rsp.count, seen_rsp.status, seen_rsp.hash, seen_rsp.value,
                           seen_rsp.count);
            end
         end
      end
   end

   task automatic test_directed_cases();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_word(CMD_POP_FRONT, '0, '0);
      send_word(CMD_POP_BACK, '1, '1);
      send_word(CMD_REMOVE, 32'h0000_0005, '0);
      send_word(CMD_LOOKUP, '1, '0);
      send_word(CMD_SPARE_6, 32'h1234_5678, 32'h9ABC_DEF0);
      send_word(CMD_PUSH_FRONT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(CMD_PUSH_BACK, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(CMD_PUSH_FRONT, 32'h8000_0001, 32'h7FFF_FFFE);
      send_word(CMD_PUSH_BACK, 32'h0000_0000, 32'h5555_5555);
      send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
      send_word(CMD_LOOKUP, 32'h0000_0000, '0);
      send_word(CMD_LOOKUP, 32'h0000_0001, '0);
      send_word(CMD_SPARE_7, '1, '1);
      send_word(CMD_REMOVE, 32'h0000_0000, '0);
      send_word(CMD_POP_BACK, '0, '0);
      send_word(CMD_POP_FRONT, '0, '0);
      send_word(CMD_POP_FRONT, '0, '0);
   endtask

   // The response side holds off while pushes keep coming, so the block
   // fills its pipeline and the store itself runs full.
   task automatic test_backpressure_fill();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < CAPACITY + 2; i++)
         send_word((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                   {8'hC3, 16'($urandom), 8'(i)}, $urandom);
      send_word(CMD_PUSH_BACK, held_hash[5], $urandom);
      send_word(CMD_REMOVE, held_hash[7], '0);
      send_word(CMD_LOOKUP, held_hash[CAPACITY - 2], '0);
      send_word(CMD_POP_FRONT, '0, '0);
      send_word(CMD_POP_BACK, '0, '0);
   endtask

   // Phases alternate between filling and draining the store; the first
   // phase runs without gaps on either side.
   task automatic test_random_mix(input int phases, input int per_phase);
      logic [HASH_W-1:0] pool [POOL_SIZE];
      logic [CMD_W-1:0] cmd;
      logic [HASH_W-1:0] h;
      logic [VALUE_W-1:0] v;
      int choice;
      int sel;
      bit filling;
      bit is_push;
      foreach (pool[k]) pool[k] = $urandom;
      pool[0] = '0;
      pool[1] = '1;
      for (int p = 0; p < phases; p++) begin
         filling = (p % 2 == 0);
         req_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
         repeat (per_phase) begin
            choice = $urandom_range(0, 99);
            if (choice < (filling ? 55 : 25))
               cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (choice < (filling ? 65 : 45))
               cmd = CMD_REMOVE;
            else if (choice < 75)
               cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            else if (choice < 93)
               cmd = CMD_LOOKUP;
            else
               cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
            is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
            sel = $urandom_range(0, 99);
            if (held_count > 0 && sel < (is_push ? 20 : 60))
               h = held_hash[$urandom_range(0, held_count - 1)];
            else if (sel < 85)
               h = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               h = $urandom;
            case ($urandom_range(0, 9))
               0: v = '0;
               1: v = '1;
               default: v = $urandom;
            endcase
            send_word(cmd, h, v);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.key_hash = '0;
      req_bus.entry_value = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_backpressure_fill();
      test_random_mix(6, 100);
      req_bus.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("Sent %0d commands and checked %0d responses, %0d mismatches.",
               commands_sent, responses_checked, mismatch_count);
      $display({"Seen: %0d duplicate pushes, %0d pushes into a full store,",
                " %0d misses, %0d empty pops."},
               duplicate_rejects, full_rejects, misses, empty_pops);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("unique_key_deque_unit_tb OK");
      else
         $display("unique_key_deque_unit_tb NOT OK");
      $finish;
   end

endmodule
